// ----- src/mm4_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants of the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int Dim      = 4;
  localparam int ElemW    = 16;
  localparam int ProdW    = 2 * ElemW;
  localparam int OutW     = 2 * ElemW + 2;
  localparam int RowW     = 2;
  localparam int InDataW  = 72;
  localparam int OutDataW = 144;
  localparam int QDepth   = 4;
  localparam int QPtrW    = 2;
  localparam int QCntW    = 3;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_MUL  = 1'b1
  } req_e;

  typedef struct packed {
    req_e                        req;
    logic [RowW-1:0]             row;
    logic [Dim-1:0][ElemW-1:0]   elem;
  } item_t;

endpackage

// ----- src/mm4_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_front
// Request intake: unpacks stream requests and queues them for the back end.
// ----------------------------------------------------------------------------
module mm4_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [mm4_pkg::InDataW-1:0] s_axis_tdata,
  input  logic                        s_axis_tuser,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output mm4_pkg::item_t              q_item_o
);

  mm4_pkg::item_t                  mem_q [mm4_pkg::QDepth];
  mm4_pkg::item_t                  wr_item;
  logic [mm4_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [mm4_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [mm4_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                            push, pop;

  function automatic logic [mm4_pkg::QCntW-1:0] QCntExt(input logic b);
    return {{(mm4_pkg::QCntW-1){1'b0}}, b};
  endfunction

  always_comb begin
    wr_item.req = mm4_pkg::req_e'(s_axis_tuser);
    wr_item.row = s_axis_tdata[mm4_pkg::RowW-1:0];
    for (int k = 0; k < mm4_pkg::Dim; k++) begin
      wr_item.elem[k] = s_axis_tdata[mm4_pkg::RowW + k*mm4_pkg::ElemW +: mm4_pkg::ElemW];
    end
  end

  assign s_axis_tready = (cnt_q != mm4_pkg::QCntW'(mm4_pkg::QDepth));
  assign q_valid_o     = (cnt_q != '0);
  assign q_item_o      = mem_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntExt(push) - QCntExt(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item;
    end
  end

endmodule

// ----- src/mm4_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_back
// Execution: holds the B matrix, multiplies an A row in sixteen lanes and
// sums each column into the output register.
// ----------------------------------------------------------------------------
module mm4_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  mm4_pkg::item_t               q_item_i,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [mm4_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int SumsW = mm4_pkg::RowW + mm4_pkg::Dim * mm4_pkg::OutW;

  logic [mm4_pkg::Dim-1:0][mm4_pkg::Dim-1:0][mm4_pkg::ElemW-1:0] b_q;
  logic signed [mm4_pkg::ProdW-1:0] prod_q [mm4_pkg::Dim][mm4_pkg::Dim];
  logic [mm4_pkg::RowW-1:0]         s1_row_q;
  logic                             s1_valid_q;
  logic [mm4_pkg::Dim-1:0][mm4_pkg::OutW-1:0] sum_d, sum_q;
  logic [mm4_pkg::RowW-1:0]         out_row_q;
  logic                             out_valid_q;
  logic                             advance, take;

  assign advance   = !out_valid_q || m_axis_tready;
  assign q_ready_o = advance;
  assign take      = q_valid_i && advance;

  // b matrix, no reset
  always_ff @(posedge clk_i) begin
    if (take && q_item_i.req == mm4_pkg::REQ_LOAD) begin
      b_q[q_item_i.row] <= q_item_i.elem;
    end
  end

  // product lanes: prod[j][k] = a[k] * b[k][j]
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_row_q <= q_item_i.row;
      for (int j = 0; j < mm4_pkg::Dim; j++) begin
        for (int k = 0; k < mm4_pkg::Dim; k++) begin
          prod_q[j][k] <= $signed(q_item_i.elem[k]) * $signed(b_q[k][j]);
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < mm4_pkg::Dim; j++) begin
      sum_d[j] = '0;
      for (int k = 0; k < mm4_pkg::Dim; k++) begin
        sum_d[j] = sum_d[j] + {{(mm4_pkg::OutW-mm4_pkg::ProdW){prod_q[j][k][mm4_pkg::ProdW-1]}},
                               prod_q[j][k]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      sum_q     <= sum_d;
      out_row_q <= s1_row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= take && (q_item_i.req == mm4_pkg::REQ_MUL);
      out_valid_q <= s1_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(mm4_pkg::OutDataW-SumsW){1'b0}}, sum_q, out_row_q};

endmodule

// ----- src/matrix_multiply_4x4.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// Row-streaming Q8.8 matrix multiplier, one product row of A x B per multiply request.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries requests. tuser = 0 loads row tdata[1:0] of B with the
//   four elements, tuser = 1 multiplies an A row and returns one product row.
//   Loads return nothing; a multiply sees every load accepted before it.
//   m_axis returns the row index and four exact Q18.16 sums in 34 bits.
// throughput: one request per cycle while no result is held, set by the
//   sixteen multiplier lanes and the two-stage multiply/sum pipeline
//   behind a 4-entry request queue.
// reset: queue and pipeline empty; B holds nothing defined until loaded.
// stall: a held result stops the pipeline; the queue keeps accepting
//   until its 4 entries are full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // row_index, elem0, elem1, elem2, elem3, zero pad
  input  logic [mm4_pkg::InDataW-1:0]  s_axis_tdata,
  // req_type
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_row, out0, out1, out2, out3, zero pad
  output logic [mm4_pkg::OutDataW-1:0] m_axis_tdata
);

  logic           q_valid, q_ready;
  mm4_pkg::item_t q_item;

  mm4_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_ready_i     (q_ready),
    .q_item_o      (q_item)
  );

  mm4_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_item_i      (q_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
